// ----- hdl/wsmc_pkg.sv -----
// shared types, constants and helper functions for the watch / stopwatch controller
// no dependencies; used by the time counter, mode machine, top level and testbench
package wsmc_pkg;

    localparam int TPT_W = 16;
    localparam logic [TPT_W-1:0] TPT_RESET = 16'd100;

    localparam int TENTHS_W = 4;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int VALUE_W  = 16;
    localparam int DP_W     = 4;
    localparam int MODE_W   = 3;

    localparam logic [4:0] TENTHS_WRAP = 5'd10;
    localparam logic [6:0] SEC_WRAP    = 7'd60;
    localparam logic [6:0] MIN_WRAP    = 7'd60;
    localparam logic [SEC_W-1:0] HALF_SECOND = 6'd5;
    localparam logic [TENTHS_W-1:0] HALF_TENTHS = 4'd5;

    // decimal point bit positions
    localparam int DP_SW_TENTHS = 1;
    localparam int DP_WATCH_SEC = 2;
    localparam int DP_SW_SEC    = 3;

    // weights of the display digits
    localparam logic [VALUE_W-1:0] WATCH_MIN_WEIGHT = 16'd100;
    localparam logic [VALUE_W-1:0] SW_MIN_WEIGHT    = 16'd1000;
    localparam logic [VALUE_W-1:0] SW_SEC_WEIGHT    = 16'd10;

    typedef struct packed {
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [TENTHS_W-1:0] tenths;
    } time_t;

    // per-step control from the mode machine to a time counter
    typedef struct packed {
        logic count_en;
        logic clr_prescale;
        logic clr_time;
    } cnt_ctl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] display_value;
        logic [DP_W-1:0]    decimal_points;
        logic               display_write;
        logic [MODE_W-1:0]  mode;
    } result_t;

    // one tenth-second step with wrap at 10, 60 and 60
    function automatic time_t advance_time(input time_t t);
        logic [4:0] tenths_inc;
        logic [6:0] sec_inc;
        logic [6:0] min_inc;
        time_t      r;
        r = t;
        tenths_inc = {1'b0, t.tenths} + 5'd1;
        if (tenths_inc >= TENTHS_WRAP)
        begin
            r.tenths = '0;
            sec_inc  = {1'b0, t.seconds} + 7'd1;
        end
        else
        begin
            r.tenths = tenths_inc[TENTHS_W-1:0];
            sec_inc  = {1'b0, t.seconds};
        end
        if (sec_inc >= SEC_WRAP)
        begin
            r.seconds = '0;
            min_inc   = {1'b0, t.minutes} + 7'd1;
        end
        else
        begin
            r.seconds = sec_inc[SEC_W-1:0];
            min_inc   = {1'b0, t.minutes};
        end
        if (min_inc >= MIN_WRAP)
            r.minutes = '0;
        else
            r.minutes = min_inc[MIN_W-1:0];
        return r;
    endfunction

    // true when the units digit of the seconds is 5 or more
    // divide by ten through multiply by 205 and shift by 11 (exact below 1024)
    function automatic logic units_ge_half(input logic [SEC_W-1:0] sec);
        logic [13:0]      prod;
        logic [2:0]       quot;
        logic [SEC_W-1:0] rem;
        prod = {8'd0, sec} * 14'd205;
        quot = prod[13:11];
        rem  = sec - SEC_W'({3'd0, quot} * 6'd10);
        return rem >= HALF_SECOND;
    endfunction

endpackage

// ----- hdl/wsmc_in_if.sv -----
// input channel: one word per step with tick and button push flags
// no dependencies
interface wsmc_in_if;
    logic valid;
    logic ready;
    logic tick;
    logic btn_a_pushed;
    logic btn_b_pushed;
    logic btn_c_pushed;

    modport source (output valid, output tick, output btn_a_pushed,
                    output btn_b_pushed, output btn_c_pushed, input ready);
    modport sink   (input valid, input tick, input btn_a_pushed,
                    input btn_b_pushed, input btn_c_pushed, output ready);
endinterface

// ----- hdl/wsmc_out_if.sv -----
// output channel: one display word per step
// no dependencies
interface wsmc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] display_value;
    logic [3:0]  decimal_points;
    logic        display_write;
    logic [2:0]  mode;

    modport source (output valid, output display_value, output decimal_points,
                    output display_write, output mode, input ready);
    modport sink   (input valid, input display_value, input decimal_points,
                    input display_write, input mode, output ready);
endinterface

// ----- hdl/watch_stopwatch_mode_controller_unit.sv -----
// watch / stopwatch mode controller, top level
// an accepted word waits in the input stage; its result word is registered in the result stage
// throughput: one word per cycle while disp.ready stays high; the limit is the state update in the mode machine
// reset (rst_n, async, active low): start mode, all counters and prescalers zero,
// ticks_per_tenth back to 100, both pipeline stages empty; no clearing pass
// depends on wsmc_pkg, wsmc_in_if, wsmc_out_if, wsmc_time_counter, wsmc_mode_fsm
module watch_stopwatch_mode_controller_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [wsmc_pkg::TPT_W-1:0]  cfg_wr_data,
    wsmc_in_if.sink                     evt,
    wsmc_out_if.source                  disp
);

    // configuration: ticks between tenth-second advances
    logic [wsmc_pkg::TPT_W-1:0] tpt_reg;

    // input stage: holds one accepted word
    logic s1_valid_reg;
    logic s1_tick_reg;
    logic s1_btn_a_reg;
    logic s1_btn_b_reg;
    logic s1_btn_c_reg;

    // result stage
    logic                out_valid_reg;
    wsmc_pkg::result_t   out_reg;

    logic                out_free;
    logic                step;
    logic                in_take;
    wsmc_pkg::time_t     watch_time;
    wsmc_pkg::time_t     sw_time;
    wsmc_pkg::cnt_ctl_t  sw_ctl;
    wsmc_pkg::cnt_ctl_t  watch_ctl;
    wsmc_pkg::result_t   result;

    // the result register frees up when empty or when its word is taken
    assign out_free  = !out_valid_reg || disp.ready;
    // the held word is processed (state updated, result captured) once the result register is free
    assign step      = s1_valid_reg && out_free;
    assign evt.ready = !s1_valid_reg || step;
    assign in_take   = evt.valid && evt.ready;

    // the watch is free running and never cleared
    assign watch_ctl = '{count_en: 1'b1, clr_prescale: 1'b0, clr_time: 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpt_reg <= wsmc_pkg::TPT_RESET;
        else if (cfg_wr_en)
            tpt_reg <= cfg_wr_data;
    end

    // control for both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (disp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_tick_reg  <= evt.tick;
            s1_btn_a_reg <= evt.btn_a_pushed;
            s1_btn_b_reg <= evt.btn_b_pushed;
            s1_btn_c_reg <= evt.btn_c_pushed;
        end
        if (step)
            out_reg <= result;
    end

    wsmc_time_counter u_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .tick            (s1_tick_reg),
        .ticks_per_tenth (tpt_reg),
        .ctl             (watch_ctl),
        .adv_time        (watch_time)
    );

    // stopwatch counts on the run flag as it stood before this word
    wsmc_time_counter u_stopwatch (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .tick            (s1_tick_reg),
        .ticks_per_tenth (tpt_reg),
        .ctl             (sw_ctl),
        .adv_time        (sw_time)
    );

    // mode machine sees the times after this word's advance
    wsmc_mode_fsm u_mode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .btn_a      (s1_btn_a_reg),
        .btn_b      (s1_btn_b_reg),
        .btn_c      (s1_btn_c_reg),
        .watch_time (watch_time),
        .sw_time    (sw_time),
        .sw_ctl     (sw_ctl),
        .result     (result)
    );

    assign disp.valid          = out_valid_reg;
    assign disp.display_value  = out_reg.display_value;
    assign disp.decimal_points = out_reg.decimal_points;
    assign disp.display_write  = out_reg.display_write;
    assign disp.mode           = out_reg.mode;

endmodule

// ----- hdl/wsmc_time_counter.sv -----
// prescaler plus tenths / seconds / minutes counter, one instance per time base
// depends on wsmc_pkg
module wsmc_time_counter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   tick,
    input  logic [wsmc_pkg::TPT_W-1:0] ticks_per_tenth,
    input  wsmc_pkg::cnt_ctl_t     ctl,
    output wsmc_pkg::time_t        adv_time
);

    logic [wsmc_pkg::TPT_W-1:0] prescale_reg;
    logic [wsmc_pkg::TPT_W-1:0] prescale_next;
    logic [wsmc_pkg::TPT_W-1:0] prescale_inc;
    logic [wsmc_pkg::TPT_W-1:0] prescale_after;
    wsmc_pkg::time_t            time_reg;
    wsmc_pkg::time_t            time_next;
    logic                       counting;
    logic                       hit;

    always_comb
    begin
        counting     = tick && ctl.count_en;
        prescale_inc = prescale_reg + 1'b1;
        hit          = counting && (prescale_inc >= ticks_per_tenth);
        if (!counting)
            prescale_after = prescale_reg;
        else if (hit)
            prescale_after = '0;
        else
            prescale_after = prescale_inc;
        adv_time = hit ? wsmc_pkg::advance_time(time_reg) : time_reg;
        // clears from the mode machine win over the advance
        prescale_next = ctl.clr_prescale ? '0 : prescale_after;
        time_next     = ctl.clr_time ? '0 : adv_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            time_reg     <= '0;
        end
        else if (step)
        begin
            prescale_reg <= prescale_next;
            time_reg     <= time_next;
        end
    end

endmodule

// ----- hdl/wsmc_mode_fsm.sv -----
// mode machine: button handling, run flag and display formatting
// depends on wsmc_pkg
module wsmc_mode_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                btn_a,
    input  logic                btn_b,
    input  logic                btn_c,
    input  wsmc_pkg::time_t     watch_time,
    input  wsmc_pkg::time_t     sw_time,
    output wsmc_pkg::cnt_ctl_t  sw_ctl,
    output wsmc_pkg::result_t   result
);

    typedef enum logic [wsmc_pkg::MODE_W-1:0] {
        MODE_START = 3'd0,
        MODE_WATCH = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_RUN   = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  running_reg;
    logic  running_next;
    logic  sw_view;

    always_comb
    begin
        mode_next    = mode_reg;
        running_next = running_reg;
        sw_view      = 1'b0;
        result       = '0;
        result.mode  = mode_reg;
        sw_ctl.count_en     = running_reg;
        sw_ctl.clr_prescale = (mode_reg == MODE_STOP);
        sw_ctl.clr_time     = (mode_reg == MODE_CLEAR);

        unique case (mode_reg)
            MODE_WATCH:
            begin
                result.display_value =
                    wsmc_pkg::VALUE_W'(watch_time.minutes) * wsmc_pkg::WATCH_MIN_WEIGHT
                    + wsmc_pkg::VALUE_W'(watch_time.seconds);
                result.decimal_points[wsmc_pkg::DP_WATCH_SEC] =
                    wsmc_pkg::units_ge_half(watch_time.seconds);
                result.display_write = 1'b1;
                if (btn_a)
                    mode_next = running_reg ? MODE_RUN : MODE_STOP;
            end
            MODE_RUN:
            begin
                running_next = 1'b1;
                sw_view      = 1'b1;
                if (btn_a)
                    mode_next = MODE_WATCH;
                else if (btn_b)
                    mode_next = MODE_STOP;
            end
            MODE_STOP:
            begin
                running_next = 1'b0;
                sw_view      = 1'b1;
                if (btn_a)
                    mode_next = MODE_WATCH;
                else if (btn_b)
                    mode_next = MODE_RUN;
                else if (btn_c)
                    mode_next = MODE_CLEAR;
            end
            MODE_CLEAR:
            begin
                mode_next = MODE_STOP;
            end
            MODE_START:
            begin
                mode_next = MODE_WATCH;
            end
            default:
            begin
                mode_next = MODE_WATCH;
            end
        endcase

        if (sw_view)
        begin
            result.display_value =
                wsmc_pkg::VALUE_W'(sw_time.minutes) * wsmc_pkg::SW_MIN_WEIGHT
                + wsmc_pkg::VALUE_W'(sw_time.seconds) * wsmc_pkg::SW_SEC_WEIGHT
                + wsmc_pkg::VALUE_W'(sw_time.tenths);
            result.decimal_points[wsmc_pkg::DP_SW_TENTHS] =
                (sw_time.tenths >= wsmc_pkg::HALF_TENTHS);
            result.decimal_points[wsmc_pkg::DP_SW_SEC] =
                wsmc_pkg::units_ge_half(sw_time.seconds);
            result.display_write = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_START;
            running_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            running_reg <= running_next;
        end
    end

    // clear always hands over to the stopped view
    a_clear_to_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_CLEAR) |=> (mode_reg == MODE_STOP))
        else $error("clear did not return to stop");

    // a step in run leaves the run flag set, a step in stop leaves it clear
    a_run_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_RUN) |=> running_reg)
        else $error("run flag not set after run step");

    a_stop_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == MODE_STOP) |=> !running_reg)
        else $error("run flag not cleared after stop step");

    // no step, no change of mode or run flag
    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(mode_reg) && $stable(running_reg)))
        else $error("mode state moved without a step");

    // a word that does not write the display is blank
    a_blank_when_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !result.display_write |-> (result.display_value == '0 && result.decimal_points == '0))
        else $error("non-writing word carries display data");

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for watch_stopwatch_mode_controller_unit
// depends on wsmc_pkg, wsmc_in_if, wsmc_out_if and the block's rtl
// predicts every display word from its own model of watch, stopwatch and mode machine
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // mode codes as they appear on the mode field of a display word
    typedef enum logic [wsmc_pkg::MODE_W-1:0] {
        MODE_START = 3'd0,
        MODE_WATCH = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_RUN   = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    // one input word, tick in the msb
    typedef struct packed {
        logic tick;
        logic btn_a;
        logic btn_b;
        logic btn_c;
    } evt_word_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    // watch and stopwatch predictor with its queue of expected display words
    class watch_display_model;
        logic [wsmc_pkg::TPT_W-1:0] period;
        mode_t                      mode;
        logic                       sw_running;
        logic [wsmc_pkg::TPT_W-1:0] watch_pre;
        logic [wsmc_pkg::TPT_W-1:0] sw_pre;
        wsmc_pkg::time_t            watch_t;
        wsmc_pkg::time_t            sw_t;
        wsmc_pkg::result_t          expected_display_q[$];
        int                         mismatch_count;

        function new();
            period         = wsmc_pkg::TPT_RESET;
            mode           = MODE_START;
            sw_running     = 1'b0;
            watch_pre      = '0;
            sw_pre         = '0;
            watch_t        = '0;
            sw_t           = '0;
            mismatch_count = 0;
        endfunction

        function void set_period(input logic [wsmc_pkg::TPT_W-1:0] v);
            period = v;
        endfunction

        function int pending();
            return expected_display_q.size();
        endfunction

        // true when this tick completes a tenth
        function logic prescale_step(inout logic [wsmc_pkg::TPT_W-1:0] cnt);
            cnt = cnt + 1'b1;
            if (cnt >= period)
            begin
                cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function wsmc_pkg::time_t next_tenth(input wsmc_pkg::time_t t);
            int tn;
            int sc;
            int mn;
            tn = int'(t.tenths) + 1;
            sc = int'(t.seconds);
            mn = int'(t.minutes);
            if (tn >= 10)
            begin
                tn = 0;
                sc = sc + 1;
            end
            if (sc >= 60)
            begin
                sc = 0;
                mn = mn + 1;
            end
            if (mn >= 60)
                mn = 0;
            next_tenth.tenths  = wsmc_pkg::TENTHS_W'(tn);
            next_tenth.seconds = wsmc_pkg::SEC_W'(sc);
            next_tenth.minutes = wsmc_pkg::MIN_W'(mn);
        endfunction

        function void note_word(input evt_word_t w);
            wsmc_pkg::result_t r;
            mode_t             shown;
            logic              sw_view;
            r       = '0;
            shown   = mode;
            sw_view = 1'b0;

            // counters first, stopwatch with the running flag from before this word
            if (w.tick)
            begin
                if (prescale_step(watch_pre))
                    watch_t = next_tenth(watch_t);
                if (sw_running)
                begin
                    if (prescale_step(sw_pre))
                        sw_t = next_tenth(sw_t);
                end
            end

            case (mode)
                MODE_WATCH:
                begin
                    if (int'(watch_t.seconds) % 10 >= 5)
                        r.decimal_points[wsmc_pkg::DP_WATCH_SEC] = 1'b1;
                    r.display_value = wsmc_pkg::VALUE_W'(int'(watch_t.minutes) * 100
                                                         + int'(watch_t.seconds));
                    r.display_write = 1'b1;
                    if (w.btn_a)
                        mode = sw_running ? MODE_RUN : MODE_STOP;
                end
                MODE_RUN:
                begin
                    sw_running = 1'b1;
                    sw_view    = 1'b1;
                    if (w.btn_a)
                        mode = MODE_WATCH;
                    else if (w.btn_b)
                        mode = MODE_STOP;
                end
                MODE_STOP:
                begin
                    sw_running = 1'b0;
                    sw_pre     = '0;
                    sw_view    = 1'b1;
                    if (w.btn_a)
                        mode = MODE_WATCH;
                    else if (w.btn_b)
                        mode = MODE_RUN;
                    else if (w.btn_c)
                        mode = MODE_CLEAR;
                end
                MODE_CLEAR:
                begin
                    sw_t = '0;
                    mode = MODE_STOP;
                end
                default:
                    mode = MODE_WATCH;
            endcase

            if (sw_view)
            begin
                if (sw_t.tenths >= 4'd5)
                    r.decimal_points[wsmc_pkg::DP_SW_TENTHS] = 1'b1;
                if (int'(sw_t.seconds) % 10 >= 5)
                    r.decimal_points[wsmc_pkg::DP_SW_SEC] = 1'b1;
                r.display_value = wsmc_pkg::VALUE_W'(int'(sw_t.minutes) * 1000
                                                     + int'(sw_t.seconds) * 10
                                                     + int'(sw_t.tenths));
                r.display_write = 1'b1;
            end
            r.mode = shown;
            expected_display_q.push_back(r);
        endfunction

        function void compare_field(input string name, input int exp, input int act);
            if (exp != act)
            begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatch_count++;
            end
        endfunction

        function void check_display(input wsmc_pkg::result_t got);
            wsmc_pkg::result_t exp;
            if (expected_display_q.size() == 0)
            begin
                $error("display word with nothing expected: value %0d mode %0d",
                       got.display_value, got.mode);
                mismatch_count++;
                return;
            end
            exp = expected_display_q.pop_front();
            compare_field("display_value", exp.display_value, got.display_value);
            compare_field("decimal_points", exp.decimal_points, got.decimal_points);
            compare_field("display_write", exp.display_write, got.display_write);
            compare_field("mode", exp.mode, got.mode);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [wsmc_pkg::TPT_W-1:0] cfg_wr_data;

    wsmc_in_if  evt_ch ();
    wsmc_out_if disp_ch ();

    watch_display_model sb;

    // idling percentages, changed between phases
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    watch_stopwatch_mode_controller_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt         (evt_ch),
        .disp        (disp_ch)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    // receiver: ready redrawn at every falling edge
    always @(negedge clk)
        disp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // output monitor: sampled at the rising edge, before the block updates
    always @(posedge clk)
    begin
        wsmc_pkg::result_t got;
        if (rst_n && disp_ch.valid && disp_ch.ready)
        begin
            got.display_value  = disp_ch.display_value;
            got.decimal_points = disp_ch.decimal_points;
            got.display_write  = disp_ch.display_write;
            got.mode           = disp_ch.mode;
            sb.check_display(got);
        end
    end

    // watchdog: ends the run after too many cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (disp_ch.valid && disp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // random input word: ticks on most words, button pushes now and then
    function automatic evt_word_t random_word();
        evt_word_t w;
        w.tick  = ($urandom_range(0, 99) < 80);
        w.btn_a = ($urandom_range(0, 99) < 12);
        w.btn_b = ($urandom_range(0, 99) < 12);
        w.btn_c = ($urandom_range(0, 99) < 12);
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    // valid stays high so back-to-back words need no extra assignment
    task automatic send_word(input evt_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.tick         <= w.tick;
        evt_ch.btn_a_pushed <= w.btn_a;
        evt_ch.btn_b_pushed <= w.btn_b;
        evt_ch.btn_c_pushed <= w.btn_c;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
        // valid drops only once the phase is done
        evt_ch.valid <= 1'b0;
    endtask

    // period is only rewritten once every expected display word has come back
    task automatic write_period(input logic [wsmc_pkg::TPT_W-1:0] v);
        while (sb.pending() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_period(v);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // walks every mode and every button priority; words are {tick, a, b, c}
    task automatic directed_part();
        send_word(4'b1111);   // start: buttons ignored, goes to watch
        send_word(4'b0000);   // watch display
        send_word(4'b1011);   // watch ignores b and c
        send_word(4'b0100);   // a: watch to stopwatch stopped
        send_word(4'b1000);   // stopped: tick does not count
        send_word(4'b0010);   // b: start running
        send_word(4'b1000);   // running flag takes hold here
        send_word(4'b1001);   // running ignores c
        send_word(4'b0110);   // a wins over b: back to watch
        send_word(4'b1100);   // a with stopwatch running: to running view
        send_word(4'b1011);   // b: stop; running ignores c
        send_word(4'b0001);   // c while stopped: clear
        send_word(4'b1111);   // clear ignores buttons, back to stopped
        send_word(4'b0111);   // a wins over b and c
        send_word(4'b0100);   // watch to stopped view
        send_word(4'b0011);   // b wins over c: run
        send_word(4'b1000);
        send_word(4'b0100);   // running to watch
        send_word(4'b0100);   // watch back to running view
        send_word(4'b0010);   // stop
        send_word(4'b1001);   // tick while stopped, then clear
        send_word(4'b0000);   // clear to stopped
    endtask

    initial
    begin
        sb                   = new();
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        evt_ch.valid         = 1'b0;
        evt_ch.tick          = 1'b0;
        evt_ch.btn_a_pushed  = 1'b0;
        evt_ch.btn_b_pushed  = 1'b0;
        evt_ch.btn_c_pushed  = 1'b0;
        disp_ch.ready        = 1'b0;
        idle_cycles          = 0;
        set_idling(0, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset period of 100, long enough for the watch to advance a tenth
        directed_part();
        run_random(120);

        // fastest nonzero period, sender idling
        write_period(16'd1);
        set_idling(68, 0);
        run_random(70);

        // longest period, receiver stalling; prescalers pile up
        write_period(16'hFFFF);
        set_idling(0, 68);
        run_random(40);

        // period dropped below the piled-up prescaler, both sides idling
        write_period(16'd2);
        set_idling(23, 23);
        run_random(60);

        // zero period: every tick is a tenth
        write_period(16'd0);
        set_idling(0, 0);
        run_random(70);

        write_period(16'd3);
        set_idling(68, 68);
        run_random(50);

        // drain, then keep watching for any stray word
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/wsmc_pkg.sv
hdl/wsmc_in_if.sv
hdl/wsmc_out_if.sv
hdl/wsmc_time_counter.sv
hdl/wsmc_mode_fsm.sv
hdl/watch_stopwatch_mode_controller_unit.sv
sim/tb.sv
